>>> hdl/edm_pkg.sv
// Shared types and constants for the edit-distance-one dictionary match unit.
// No dependencies.
package edm_pkg;

    localparam int unsigned PORT_CHARS_W = 128;
    localparam int unsigned IN_LEN_W     = 5;
    localparam int unsigned OUT_IDX_W    = 6;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUGG_RD,
        S_SUGG_OUT,
        S_FINAL
    } t_state;

    typedef enum logic [1:0] {
        KIND_CORRECT = 2'd0,
        KIND_SUGGEST = 2'd1,
        KIND_NONE    = 2'd2,
        KIND_FULL    = 2'd3
    } t_kind;

    typedef struct packed {
        logic exact;
        logic near;
    } t_cmp_res;

endpackage

>>> hdl/edm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module edm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/edm_cmp.sv
// Byte-parallel compare of a query word against one dictionary entry:
// exact match and one substitution, insertion or deletion. Uses edm_pkg.
module edm_cmp #(
    parameter int MAX_BYTES = 16,
    parameter int LEN_W     = 5
) (
    input  logic [MAX_BYTES*8-1:0] i_q_bytes,
    input  logic [LEN_W-1:0]       i_q_len,
    input  logic [MAX_BYTES*8-1:0] i_e_bytes,
    input  logic [LEN_W-1:0]       i_e_len,
    output edm_pkg::t_cmp_res      o_res
);
    import edm_pkg::*;

    logic [MAX_BYTES-1:0]   w_neq;
    logic [MAX_BYTES-1:0]   w_eq1;
    logic [MAX_BYTES-1:0]   w_pre;
    logic [MAX_BYTES-1:0]   w_bad;
    logic [MAX_BYTES*8-1:0] w_s;
    logic [MAX_BYTES*8-1:0] w_l;
    logic [LEN_W-1:0]       w_ls;
    logic [LEN_W:0]         w_ql1;
    logic [LEN_W:0]         w_el1;
    logic                   w_same;
    logic                   w_q_short;
    logic                   w_e_short;
    logic                   w_one_diff;

    assign w_ql1     = {1'b0, i_q_len} + {{LEN_W{1'b0}}, 1'b1};
    assign w_el1     = {1'b0, i_e_len} + {{LEN_W{1'b0}}, 1'b1};
    assign w_same    = (i_q_len == i_e_len);
    assign w_q_short = (w_ql1 == {1'b0, i_e_len});
    assign w_e_short = (w_el1 == {1'b0, i_q_len});

    // shorter word in s, longer in l
    assign w_s  = w_q_short ? i_q_bytes : i_e_bytes;
    assign w_l  = w_q_short ? i_e_bytes : i_q_bytes;
    assign w_ls = w_q_short ? i_q_len : i_e_len;

    for (genvar g = 0; g < MAX_BYTES; g++) begin : g_byte
        assign w_neq[g] = (i_q_bytes[8*g +: 8] != i_e_bytes[8*g +: 8]);
        assign w_pre[g] = |w_neq[g:0];
        if (g < MAX_BYTES - 1) begin : g_shift
            assign w_eq1[g] = (w_s[8*g +: 8] == w_l[8*g+8 +: 8]);
        end else begin : g_edge
            assign w_eq1[g] = 1'b1;
        end
        // past the first mismatch the shorter word must match shifted by one
        assign w_bad[g] = (LEN_W'(g) < w_ls) && !w_eq1[g] && w_pre[g];
    end

    assign w_one_diff = (w_neq != '0) && ((w_neq & (w_neq - MAX_BYTES'(1))) == '0);

    assign o_res.exact = w_same && (w_neq == '0);
    assign o_res.near  = (w_same && w_one_diff) ||
                         ((w_q_short || w_e_short) && (w_bad == '0));

endmodule

>>> hdl/edit_distance_one_dictionary_match_unit.sv
// Spell checker over a stored dictionary; uses edm_pkg, edm_ram, edm_cmp.
// Load: no result unless the dictionary is full (then a KIND_FULL result via S_FINAL).
// Query: one pass over the n entries, one RAM read a cycle, ending early on an exact match,
// then a walk up to the last suggestion that reads each marked entry in turn.
// Results sit in an output register.
// Reset (synchronous, active low) empties the dictionary and the FSM.
module edit_distance_one_dictionary_match_unit #(
    parameter int DICT_ENTRIES   = 64,
    parameter int MAX_WORD_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [63:0] i_word_chars_low,
    input  logic [63:0] i_word_chars_high,
    input  logic [4:0]  i_word_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [5:0]  o_entry_index,
    output logic [63:0] o_entry_chars_low,
    output logic [63:0] o_entry_chars_high,
    output logic [4:0]  o_entry_length,
    output logic        o_last_result
);
    import edm_pkg::*;

    localparam int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int CW = $clog2(DICT_ENTRIES + 1);
    localparam int WB = MAX_WORD_BYTES * 8;
    localparam int LW = $clog2(MAX_WORD_BYTES + 1);
    localparam int MW = WB + LW;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count;
    logic [WB-1:0]           r_q_bytes;
    logic [LW-1:0]           r_q_len;
    logic [CW-1:0]           r_addr;
    logic                    r_pend;
    logic [AW-1:0]           r_pend_idx;
    logic [DICT_ENTRIES-1:0] r_mask;
    logic [AW-1:0]           r_last_idx;
    logic                    r_any;
    t_kind                   r_fin_kind;
    logic [AW-1:0]           r_fin_idx;
    logic                    r_out_valid;
    t_kind                   r_o_kind;
    logic [OUT_IDX_W-1:0]    r_o_idx;
    logic [63:0]             r_o_lo;
    logic [63:0]             r_o_hi;
    logic [IN_LEN_W-1:0]     r_o_len;
    logic                    r_o_last;

    logic [PORT_CHARS_W-1:0] w_in_all;
    logic [WB-1:0]           w_in_bytes;
    logic [LW-1:0]           w_in_len;
    logic                    w_accept;
    logic                    w_slot;
    logic                    w_full;
    logic                    w_issue;
    logic                    w_sugg_hit;
    logic                    w_eval;
    logic                    w_scan_done;
    logic                    w_load_fin;
    logic                    w_load_sugg;
    logic                    w_is_last;
    logic                    w_we;
    logic                    w_re;
    logic [MW-1:0]           w_rdata;
    logic [WB-1:0]           w_rd_bytes;
    logic [LW-1:0]           w_rd_len;
    logic [PORT_CHARS_W-1:0] w_ent_all;
    t_cmp_res                w_cmp;

    assign w_in_all = {i_word_chars_high, i_word_chars_low};

    always_comb begin
        if (i_word_length > IN_LEN_W'(MAX_WORD_BYTES)) begin
            w_in_len = LW'(MAX_WORD_BYTES);
        end else begin
            w_in_len = LW'(i_word_length);
        end
    end

    for (genvar g = 0; g < MAX_WORD_BYTES; g++) begin : g_in
        assign w_in_bytes[8*g +: 8] = (LW'(g) < w_in_len) ? w_in_all[8*g +: 8] : 8'h00;
    end

    assign w_rd_bytes = w_rdata[WB-1:0];
    assign w_rd_len   = w_rdata[MW-1:WB];
    assign w_ent_all  = PORT_CHARS_W'(w_rd_bytes);

    edm_ram #(
        .WIDTH (MW),
        .DEPTH (DICT_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({w_in_len, w_in_bytes}),
        .i_re    (w_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    edm_cmp #(
        .MAX_BYTES (MAX_WORD_BYTES),
        .LEN_W     (LW)
    ) u_cmp (
        .i_q_bytes (r_q_bytes),
        .i_q_len   (r_q_len),
        .i_e_bytes (w_rd_bytes),
        .i_e_len   (w_rd_len),
        .o_res     (w_cmp)
    );

    // control decode
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        w_accept    = i_valid && o_ready;
        w_slot      = !r_out_valid || i_ready;
        w_full      = (r_count == CW'(DICT_ENTRIES));
        w_we        = w_accept && (i_func == FUNC_LOAD) && !w_full;
        w_issue     = (r_state == S_SCAN) && (r_addr < r_count);
        w_sugg_hit  = (r_state == S_SUGG_RD) && r_mask[r_addr[AW-1:0]];
        w_re        = w_issue || w_sugg_hit;
        w_eval      = (r_state == S_SCAN) && r_pend;
        w_scan_done = (r_state == S_SCAN) && !w_issue && !r_pend;
        w_load_fin  = (r_state == S_FINAL) && w_slot;
        w_load_sugg = (r_state == S_SUGG_OUT) && w_slot;
        w_is_last   = (r_addr[AW-1:0] == r_last_idx);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == FUNC_QUERY) begin
                        n_state = S_SCAN;
                    end else if (w_full) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_SCAN: begin
                priority if (w_eval && w_cmp.exact) begin
                    n_state = S_FINAL;
                end else if (w_scan_done) begin
                    n_state = r_any ? S_SUGG_RD : S_FINAL;
                end
            end
            S_SUGG_RD: begin
                if (w_sugg_hit) begin
                    n_state = S_SUGG_OUT;
                end
            end
            S_SUGG_OUT: begin
                if (w_slot) begin
                    n_state = w_is_last ? S_IDLE : S_SUGG_RD;
                end
            end
            S_FINAL: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_mask      <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_we) begin
                r_count <= r_count + CW'(1);
            end

            if (w_accept && (i_func == FUNC_QUERY)) begin
                r_q_bytes <= w_in_bytes;
                r_q_len   <= w_in_len;
                r_addr    <= '0;
                r_pend    <= 1'b0;
                r_mask    <= '0;
                r_any     <= 1'b0;
            end

            if (w_accept && (i_func == FUNC_LOAD) && w_full) begin
                r_fin_kind <= KIND_FULL;
                r_fin_idx  <= '0;
            end

            if (r_state == S_SCAN) begin
                r_pend     <= w_issue;
                r_pend_idx <= r_addr[AW-1:0];
                if (w_issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (w_eval) begin
                    if (w_cmp.exact) begin
                        r_fin_kind <= KIND_CORRECT;
                        r_fin_idx  <= r_pend_idx;
                    end else if (w_cmp.near) begin
                        r_mask[r_pend_idx] <= 1'b1;
                        r_last_idx         <= r_pend_idx;
                        r_any              <= 1'b1;
                    end
                end
                if (w_scan_done) begin
                    r_addr     <= '0;
                    r_fin_kind <= KIND_NONE;
                    r_fin_idx  <= '0;
                end
            end

            if ((r_state == S_SUGG_RD) && !w_sugg_hit) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_load_sugg) begin
                r_addr <= r_addr + CW'(1);
            end

            if (w_load_fin) begin
                r_out_valid <= 1'b1;
                r_o_kind    <= r_fin_kind;
                r_o_idx     <= OUT_IDX_W'(r_fin_idx);
                r_o_lo      <= '0;
                r_o_hi      <= '0;
                r_o_len     <= '0;
                r_o_last    <= 1'b1;
            end else if (w_load_sugg) begin
                r_out_valid <= 1'b1;
                r_o_kind    <= KIND_SUGGEST;
                r_o_idx     <= OUT_IDX_W'(r_addr[AW-1:0]);
                r_o_lo      <= w_ent_all[63:0];
                r_o_hi      <= w_ent_all[127:64];
                r_o_len     <= IN_LEN_W'(w_rd_len);
                r_o_last    <= w_is_last;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_o_kind;
    assign o_entry_index      = r_o_idx;
    assign o_entry_chars_low  = r_o_lo;
    assign o_entry_chars_high = r_o_hi;
    assign o_entry_length     = r_o_len;
    assign o_last_result      = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DICT_ENTRIES))
        else $error("entry count beyond dictionary size");

    a_sugg_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_sugg |-> r_mask[r_addr[AW-1:0]])
        else $error("suggestion emitted for an unmarked entry");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUGG_RD) |-> (r_any && (r_addr[AW-1:0] <= r_last_idx)))
        else $error("suggestion walk passed the last marked entry");

endmodule

>>> bench/tb_edit_distance_one_dictionary_match_unit.sv
// Testbench for edit_distance_one_dictionary_match_unit: loads words, queries them with
// near and random spellings, predicts every reply and checks the result stream in order.
// Depends on edm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_edit_distance_one_dictionary_match_unit;
    import edm_pkg::*;

    localparam int LEXICON_SLOTS = 64;
    localparam int WORD_BYTES    = 16;
    localparam int RANDOM_WORDS  = 480;
    localparam int CALM_TAIL     = 60;
    localparam int DRAIN_CYCLES  = 300;

    typedef struct packed {
        logic        func;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
    } t_word;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  idx;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic        last;
    } t_reply;

    typedef struct {
        logic [127:0] text;
        int           len;
    } t_spelling;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic        o_ready;
    logic        i_func             = FUNC_LOAD;
    logic [63:0] i_word_chars_low   = '0;
    logic [63:0] i_word_chars_high  = '0;
    logic [4:0]  i_word_length      = '0;
    logic        o_valid;
    logic        i_ready            = 1'b0;
    logic [1:0]  o_result_kind;
    logic [5:0]  o_entry_index;
    logic [63:0] o_entry_chars_low;
    logic [63:0] o_entry_chars_high;
    logic [4:0]  o_entry_length;
    logic        o_last_result;

    edit_distance_one_dictionary_match_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_word_chars_low   (i_word_chars_low),
        .i_word_chars_high  (i_word_chars_high),
        .i_word_length      (i_word_length),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result_kind      (o_result_kind),
        .o_entry_index      (o_entry_index),
        .o_entry_chars_low  (o_entry_chars_low),
        .o_entry_chars_high (o_entry_chars_high),
        .o_entry_length     (o_entry_length),
        .o_last_result      (o_last_result)
    );

    initial forever #4 i_clk = ~i_clk;

    logic [127:0] lexicon_text [LEXICON_SLOTS];
    int           lexicon_len  [LEXICON_SLOTS];
    int           lexicon_size = 0;
    t_reply       replies_due [$];
    t_word        words_to_send [$];
    t_spelling    planned_lexicon [$];
    int           words_taken = 0;
    int           total_words = 0;
    int           faults = 0;
    int           send_gap = 0;
    int           take_gap = 0;
    t_word        next_word;
    t_word        taken_word;
    t_reply       got_reply;
    t_reply       want_reply;

    function automatic int clip_len(logic [4:0] len);
        return (len > WORD_BYTES) ? WORD_BYTES : int'(len);
    endfunction

    function automatic logic [127:0] keep_bytes(logic [127:0] raw, int len);
        logic [127:0] res;
        int i;
        res = '0;
        for (i = 0; i < len; i++)
            res[8*i +: 8] = raw[8*i +: 8];
        return res;
    endfunction

    function automatic bit one_edit_apart(logic [127:0] a, int la, logic [127:0] b, int lb);
        logic [127:0] s, l;
        int ls, p, i, diff;
        if (la == lb) begin
            diff = 0;
            for (i = 0; i < la; i++)
                if (a[8*i +: 8] != b[8*i +: 8])
                    diff++;
            return diff == 1;
        end
        if (la + 1 == lb) begin
            s = a; ls = la; l = b;
        end else if (lb + 1 == la) begin
            s = b; ls = lb; l = a;
        end else begin
            return 1'b0;
        end
        p = 0;
        while (p < ls && s[8*p +: 8] == l[8*p +: 8])
            p++;
        for (i = p; i < ls; i++)
            if (s[8*i +: 8] != l[8*(i+1) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic check_spelling(input t_word w);
        logic [127:0] q;
        int ql, i, found;
        ql = clip_len(w.len);
        q  = keep_bytes({w.hi, w.lo}, ql);
        if (w.func == FUNC_LOAD) begin
            if (lexicon_size >= LEXICON_SLOTS) begin
                replies_due.push_back('{KIND_FULL, '0, '0, '0, '0, 1'b1});
            end else begin
                lexicon_text[lexicon_size] = q;
                lexicon_len[lexicon_size]  = ql;
                lexicon_size++;
            end
            return;
        end
        for (i = 0; i < lexicon_size; i++) begin
            if (lexicon_len[i] == ql && lexicon_text[i] == q) begin
                replies_due.push_back('{KIND_CORRECT, 6'(i), '0, '0, '0, 1'b1});
                return;
            end
        end
        found = 0;
        for (i = 0; i < lexicon_size; i++) begin
            if (one_edit_apart(q, ql, lexicon_text[i], lexicon_len[i])) begin
                replies_due.push_back('{KIND_SUGGEST, 6'(i), lexicon_text[i][63:0],
                                        lexicon_text[i][127:64], 5'(lexicon_len[i]), 1'b0});
                found++;
            end
        end
        if (found == 0)
            replies_due.push_back('{KIND_NONE, '0, '0, '0, '0, 1'b1});
        else
            replies_due[replies_due.size()-1].last = 1'b1;
    endtask

    task automatic flag_fault(input string why, input t_reply want, input t_reply got);
        faults++;
        if (faults <= 10) begin
            $display("%0t %s: want kind %0d idx %0d chars %h_%h len %0d last %0b,",
                     $realtime, why, want.kind, want.idx, want.hi, want.lo, want.len,
                     want.last);
            $display("    got kind %0d idx %0d chars %h_%h len %0d last %0b",
                     got.kind, got.idx, got.hi, got.lo, got.len, got.last);
        end
    endtask

    function automatic logic [7:0] pick_char(bit narrow);
        return narrow ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
    endfunction

    function automatic t_spelling random_spelling();
        t_spelling s;
        int r, i;
        bit narrow;
        r = $urandom_range(0, 19);
        if (r == 0)
            s.len = 0;
        else if (r == 1)
            s.len = WORD_BYTES;
        else if (r <= 4)
            s.len = $urandom_range(6, 15);
        else
            s.len = $urandom_range(1, 5);
        narrow = ($urandom_range(0, 3) != 0);
        s.text = '0;
        for (i = 0; i < s.len; i++)
            s.text[8*i +: 8] = pick_char(narrow);
        return s;
    endfunction

    function automatic t_spelling mutate(t_spelling src);
        t_spelling s;
        int n, k, p, i;
        s = src;
        n = $urandom_range(0, 5);
        n = (n == 0) ? 0 : (n == 5) ? 2 : 1;
        repeat (n) begin
            k = $urandom_range(0, 2);
            if (k == 1 && s.len == WORD_BYTES)
                k = 0;
            if (k != 1 && s.len == 0)
                k = 1;
            case (k)
                0: begin
                    p = $urandom_range(0, s.len - 1);
                    s.text[8*p +: 8] = pick_char($urandom_range(0, 4) != 0);
                end
                1: begin
                    p = $urandom_range(0, s.len);
                    for (i = s.len; i > p; i--)
                        s.text[8*i +: 8] = s.text[8*(i-1) +: 8];
                    s.text[8*p +: 8] = pick_char($urandom_range(0, 4) != 0);
                    s.len++;
                end
                default: begin
                    p = $urandom_range(0, s.len - 1);
                    for (i = p; i < s.len - 1; i++)
                        s.text[8*i +: 8] = s.text[8*(i+1) +: 8];
                    s.text[8*(s.len-1) +: 8] = 8'h00;
                    s.len--;
                end
            endcase
        end
        return s;
    endfunction

    // fill bytes beyond the length with junk; sometimes overstate a full length
    task automatic queue_spelling(input logic fn, input t_spelling s);
        t_word w;
        logic [127:0] raw;
        int i;
        raw = {$urandom, $urandom, $urandom, $urandom};
        for (i = 0; i < s.len; i++)
            raw[8*i +: 8] = s.text[8*i +: 8];
        w.func = fn;
        w.lo   = raw[63:0];
        w.hi   = raw[127:64];
        w.len  = (s.len == WORD_BYTES && $urandom_range(0, 2) == 0) ?
                 5'($urandom_range(17, 31)) : 5'(s.len);
        words_to_send.push_back(w);
        if (fn == FUNC_LOAD && planned_lexicon.size() < LEXICON_SLOTS)
            planned_lexicon.push_back(s);
    endtask

    task automatic queue_text(input logic fn, input string txt);
        t_spelling s;
        int i;
        s.text = '0;
        s.len  = txt.len();
        for (i = 0; i < s.len; i++)
            s.text[8*i +: 8] = txt[i];
        queue_spelling(fn, s);
    endtask

    task automatic queue_all_ones(input logic fn, input int len);
        t_spelling s;
        s.text = keep_bytes('1, len);
        s.len  = len;
        queue_spelling(fn, s);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                taken_word = '{i_func, i_word_chars_low, i_word_chars_high, i_word_length};
                check_spelling(taken_word);
                words_taken++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if (words_to_send.size() > 0) begin
                    next_word = words_to_send.pop_front();
                    i_func            <= next_word.func;
                    i_word_chars_low  <= next_word.lo;
                    i_word_chars_high <= next_word.hi;
                    i_word_length     <= next_word.len;
                    i_valid           <= 1'b1;
                    if (words_to_send.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got_reply = '{t_kind'(o_result_kind), o_entry_index, o_entry_chars_low,
                              o_entry_chars_high, o_entry_length, o_last_result};
                if (replies_due.size() == 0) begin
                    flag_fault("unexpected result", '0, got_reply);
                end else begin
                    want_reply = replies_due.pop_front();
                    if (got_reply !== want_reply)
                        flag_fault("result mismatch", want_reply, got_reply);
                end
            end
            if (take_gap > 0) begin
                i_ready <= 1'b0;
                take_gap--;
            end else begin
                i_ready <= 1'b1;
                if (words_to_send.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    take_gap = $urandom_range(1, 4);
            end
        end
    end

    initial begin
        int n, pick;
        t_spelling s;
        queue_text(FUNC_QUERY, "ab");
        queue_text(FUNC_LOAD,  "cat");
        queue_text(FUNC_LOAD,  "a");
        queue_text(FUNC_QUERY, "");
        queue_text(FUNC_LOAD,  "");
        words_to_send.push_back('{FUNC_LOAD, '1, '1, 5'd31});
        planned_lexicon.push_back('{keep_bytes('1, WORD_BYTES), WORD_BYTES});
        queue_text(FUNC_LOAD,  "cart");
        queue_text(FUNC_LOAD,  "cat");
        queue_text(FUNC_QUERY, "cat");
        queue_text(FUNC_QUERY, "");
        queue_text(FUNC_QUERY, "b");
        queue_text(FUNC_QUERY, "cut");
        queue_text(FUNC_QUERY, "ca");
        queue_text(FUNC_QUERY, "cats");
        queue_text(FUNC_QUERY, "carts");
        queue_all_ones(FUNC_QUERY, WORD_BYTES);
        queue_all_ones(FUNC_QUERY, WORD_BYTES - 1);
        queue_text(FUNC_QUERY, "zzzzz");
        words_to_send.push_back('{FUNC_QUERY, '0, '0, 5'd5});
        words_to_send.push_back('{FUNC_QUERY, 64'h0000_0000_0000_ff00, '1, 5'd16});

        for (n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if ((planned_lexicon.size() < LEXICON_SLOTS && pick < 40) || pick < 5) begin
                if ($urandom_range(0, 9) < 6)
                    s = mutate(planned_lexicon[$urandom_range(0, planned_lexicon.size() - 1)]);
                else
                    s = random_spelling();
                queue_spelling(FUNC_LOAD, s);
            end else begin
                if ($urandom_range(0, 99) < 85)
                    s = mutate(planned_lexicon[$urandom_range(0, planned_lexicon.size() - 1)]);
                else
                    s = random_spelling();
                queue_spelling(FUNC_QUERY, s);
            end
        end
        total_words = words_to_send.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (words_taken < total_words)
            @(posedge i_clk);
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #16_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
